/* rtl/srgr_pkg.sv */
// ----------------------------------------------------------------------------
// srgr_pkg
// Shared constants, types and font ROM for the scaled, rotated glyph renderer.
// ----------------------------------------------------------------------------
package srgr_pkg;

   localparam int LOGICAL_WIDTH  = 800;
   localparam int LOGICAL_HEIGHT = 480;
   localparam int PHYS_WIDTH     = 480;
   localparam int MAX_SCALE      = 8;

   localparam int CELL_COLS   = 6;   // dots per cell row, incl. margin
   localparam int CELL_ROWS   = 8;   // dots per cell column, incl. margin
   localparam int GLYPH_COLS  = 5;
   localparam int GLYPH_ROWS  = 7;
   localparam int GLYPH_COUNT = 39;

   localparam int X_W     = 10;
   localparam int Y_W     = 9;
   localparam int CODE_W  = 8;
   localparam int SCALE_W = 4;
   localparam int COLOR_W = 16;
   localparam int ADDR_W  = 19;
   localparam int MASK_W  = 64;
   localparam int CX_W    = 12;      // pos_x plus up to 47 columns, and the width bound
   localparam int IDX_W   = 6;

   localparam logic [IDX_W-1:0] GLYPH_BLANK = IDX_W'(GLYPH_COUNT);

   typedef logic [MASK_W-1:0] mask_type;

   typedef struct packed {
      logic load;      // latch request, clear row vectors
      logic expand;    // expand one dot row into the row vectors
      logic emit;      // present one cell column
   } cmd_type;

   typedef struct packed {
      logic expand_done;
      logic scale_zero;
      logic last_column;
   } status_type;

   localparam logic [GLYPH_COLS-1:0] GLYPH_ROM [0:GLYPH_COUNT-1][0:GLYPH_ROWS-1] = '{
      '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
      '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
      '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
      '{5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E},
      '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
      '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E},
      '{5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
      '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
      '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
      '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E},
      '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
      '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
      '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E},
      '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
      '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
      '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
      '{5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F},
      '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
      '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
      '{5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C},
      '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
      '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
      '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
      '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
      '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
      '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
      '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D},
      '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
      '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
      '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
      '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
      '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},
      '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A},
      '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
      '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},
      '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F},
      '{5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00},
      '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06},
      '{5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00}
   };

   // ASCII code to font entry; GLYPH_BLANK for codes outside the font
   function automatic logic [IDX_W-1:0] glyph_index(input logic [CODE_W-1:0] code);
      logic [IDX_W-1:0] idx;
      begin
         priority if (code >= 8'h30 && code <= 8'h39) begin
            idx = IDX_W'(code - 8'h30);
         end else if (code >= 8'h41 && code <= 8'h5A) begin
            idx = IDX_W'(code - 8'h41 + 8'd10);
         end else if (code == 8'h3A) begin
            idx = IDX_W'(36);
         end else if (code == 8'h2E) begin
            idx = IDX_W'(37);
         end else if (code == 8'h2D) begin
            idx = IDX_W'(38);
         end else begin
            idx = GLYPH_BLANK;
         end
         return idx;
      end
   endfunction

   // dot bits of one glyph row, MSB is the leftmost dot; zero outside the font
   function automatic logic [GLYPH_COLS-1:0] glyph_row(input logic [IDX_W-1:0] idx,
                                                       input logic [2:0] row);
      logic [GLYPH_COLS-1:0] bits;
      begin
         bits = '0;
         if (idx < GLYPH_BLANK && 32'(row) < GLYPH_ROWS) begin
            bits = GLYPH_ROM[idx][row];
         end
         return bits;
      end
   endfunction

endpackage

/* rtl/srgr_controller.sv */
// ----------------------------------------------------------------------------
// srgr_controller
// Sequencer: request load, dot-row expansion, then one column per cycle.
// ----------------------------------------------------------------------------
module srgr_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  srgr_pkg::status_type status,
   output srgr_pkg::cmd_type    cmd,
   output logic                 busy
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_EXPAND = 3'b010,
      ST_EMIT   = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXPAND;
            end
         end
         ST_EXPAND: begin
            cmd.expand = 1'b1;
            if (status.expand_done) begin
               state_in = status.scale_zero ? ST_IDLE : ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.last_column) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* rtl/srgr_datapath.sv */
// ----------------------------------------------------------------------------
// srgr_datapath
// Request registers, row-mask expansion and per-column result formation.
// ----------------------------------------------------------------------------
module srgr_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  srgr_pkg::cmd_type                    cmd,
   output srgr_pkg::status_type                 status,
   input  logic [srgr_pkg::X_W-1:0]             req_pos_x,
   input  logic [srgr_pkg::Y_W-1:0]             req_pos_y,
   input  logic [srgr_pkg::CODE_W-1:0]          req_char_code,
   input  logic [srgr_pkg::SCALE_W-1:0]         req_scale,
   input  logic [srgr_pkg::COLOR_W-1:0]         req_fg_color,
   input  logic [srgr_pkg::COLOR_W-1:0]         req_bg_color,
   output logic                                 rsp_strobe,
   output logic [srgr_pkg::ADDR_W-1:0]          rsp_column_address,
   output srgr_pkg::mask_type                   rsp_write_mask,
   output srgr_pkg::mask_type                   rsp_fg_mask,
   output logic [srgr_pkg::COLOR_W-1:0]         rsp_out_fg_color,
   output logic [srgr_pkg::COLOR_W-1:0]         rsp_out_bg_color,
   output logic                                 rsp_last_column
);

   // held request
   logic [srgr_pkg::IDX_W-1:0]   gidx_ff;
   logic [srgr_pkg::SCALE_W-1:0] scale_ff;
   logic [srgr_pkg::COLOR_W-1:0] fg_ff;
   logic [srgr_pkg::COLOR_W-1:0] bg_ff;
   logic                         full_ff;

   // row vectors built during expansion
   srgr_pkg::mask_type fgcol_ff [0:srgr_pkg::GLYPH_COLS-1];
   srgr_pkg::mask_type glyph_rows_ff;
   srgr_pkg::mask_type cell_rows_ff;
   srgr_pkg::mask_type screen_rows_ff;
   logic [2:0]         row_ff;
   logic [5:0]         offset_ff;

   // column walk
   logic [srgr_pkg::CX_W-1:0]   cx_ff;
   logic [srgr_pkg::ADDR_W-1:0] addr_ff;
   logic [2:0]                  dc_ff;
   logic [2:0]                  sub_ff;

   logic [srgr_pkg::SCALE_W-1:0] scale_sat;
   logic [srgr_pkg::CX_W-1:0]    span;
   logic [31:0]                  addr_start;
   logic                         full_in;
   srgr_pkg::mask_type           screen_in;
   srgr_pkg::mask_type           run;
   logic [srgr_pkg::GLYPH_COLS-1:0] dots;
   logic [2:0]                   sub_top;
   logic                         on_screen;
   logic                         glyph_col;
   srgr_pkg::mask_type           fg_sel;
   srgr_pkg::mask_type           wm_in;
   srgr_pkg::mask_type           fm_in;

   always_comb begin
      scale_sat = (32'(req_scale) > srgr_pkg::MAX_SCALE)
                ? srgr_pkg::SCALE_W'(srgr_pkg::MAX_SCALE) : req_scale;
      span       = srgr_pkg::CX_W'(srgr_pkg::LOGICAL_WIDTH - 1) - srgr_pkg::CX_W'(req_pos_x);
      addr_start = 32'(span) * 32'(srgr_pkg::PHYS_WIDTH) + 32'(req_pos_y);
      full_in    = (32'(req_pos_x) + srgr_pkg::CELL_COLS * 32'(scale_sat)
                    <= srgr_pkg::LOGICAL_WIDTH)
                && (32'(req_pos_y) + srgr_pkg::CELL_ROWS * 32'(scale_sat)
                    <= srgr_pkg::LOGICAL_HEIGHT);
      for (int i = 0; i < srgr_pkg::MASK_W; i++) begin
         screen_in[i] = (32'(req_pos_y) + 32'(i) < srgr_pkg::LOGICAL_HEIGHT);
      end
   end

   // one dot row covers scale pixel rows starting at offset
   assign run  = ((srgr_pkg::MASK_W'(1) << scale_ff) - srgr_pkg::MASK_W'(1)) << offset_ff;
   assign dots = srgr_pkg::glyph_row(gidx_ff, row_ff);

   assign sub_top   = 3'(scale_ff - 4'd1);
   assign on_screen = (32'(cx_ff) < srgr_pkg::LOGICAL_WIDTH);
   assign glyph_col = (32'(dc_ff) < srgr_pkg::GLYPH_COLS);
   assign fg_sel    = glyph_col ? fgcol_ff[dc_ff] : '0;

   always_comb begin
      wm_in = '0;
      fm_in = '0;
      if (on_screen) begin
         if (glyph_col) begin
            wm_in = (full_ff ? cell_rows_ff : glyph_rows_ff) & screen_rows_ff;
            fm_in = fg_sel & screen_rows_ff;
         end else if (full_ff) begin
            wm_in = cell_rows_ff & screen_rows_ff;
         end
      end
   end

   assign status.expand_done = (row_ff == 3'(srgr_pkg::CELL_ROWS - 1));
   assign status.scale_zero  = (scale_ff == '0);
   assign status.last_column = (32'(dc_ff) == srgr_pkg::CELL_COLS - 1) && (sub_ff == sub_top);

   // request, expansion and walk registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff    <= '0;
         offset_ff <= '0;
         dc_ff     <= '0;
         sub_ff    <= '0;
         scale_ff  <= '0;
      end else if (cmd.load) begin
         gidx_ff        <= srgr_pkg::glyph_index(req_char_code);
         scale_ff       <= scale_sat;
         fg_ff          <= req_fg_color;
         bg_ff          <= req_bg_color;
         full_ff        <= full_in;
         screen_rows_ff <= screen_in;
         glyph_rows_ff  <= '0;
         cell_rows_ff   <= '0;
         for (int k = 0; k < srgr_pkg::GLYPH_COLS; k++) begin
            fgcol_ff[k] <= '0;
         end
         row_ff    <= '0;
         offset_ff <= '0;
         cx_ff     <= srgr_pkg::CX_W'(req_pos_x);
         addr_ff   <= addr_start[srgr_pkg::ADDR_W-1:0];
         dc_ff     <= '0;
         sub_ff    <= '0;
      end else if (cmd.expand) begin
         for (int k = 0; k < srgr_pkg::GLYPH_COLS; k++) begin
            if (dots[srgr_pkg::GLYPH_COLS-1-k]) begin
               fgcol_ff[k] <= fgcol_ff[k] | run;
            end
         end
         if (32'(row_ff) < srgr_pkg::GLYPH_ROWS) begin
            glyph_rows_ff <= glyph_rows_ff | run;
         end
         cell_rows_ff <= cell_rows_ff | run;
         row_ff       <= row_ff + 3'd1;
         offset_ff    <= offset_ff + 6'(scale_ff);
      end else if (cmd.emit) begin
         cx_ff   <= cx_ff + srgr_pkg::CX_W'(1);
         addr_ff <= addr_ff - srgr_pkg::ADDR_W'(srgr_pkg::PHYS_WIDTH);
         if (sub_ff == sub_top) begin
            sub_ff <= '0;
            dc_ff  <= dc_ff + 3'd1;
         end else begin
            sub_ff <= sub_ff + 3'd1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= cmd.emit;
      end
      if (cmd.emit) begin
         rsp_column_address <= on_screen ? addr_ff : '0;
         rsp_write_mask     <= wm_in;
         rsp_fg_mask        <= fm_in;
         rsp_out_fg_color   <= fg_ff;
         rsp_out_bg_color   <= bg_ff;
         rsp_last_column    <= status.last_column;
      end
   end

endmodule

/* rtl/scaled_rotated_glyph_renderer.sv */
// ----------------------------------------------------------------------------
// scaled_rotated_glyph_renderer
// Draws one 5x7 font character, scaled and rotated, as framebuffer columns.
// ----------------------------------------------------------------------------
// The first result strobes once all eight dot rows are expanded and the first
//   column is registered into the output register.
// A new request is taken only when the sequencer is back in idle, after the
//   row expansion and the column walk; scale 0 expands the rows, no results.
// Results are strobed for one cycle each; the receiver cannot stall.
// Reset (synchronous, active high) returns the sequencer to idle and drops the strobe.
// ----------------------------------------------------------------------------
module scaled_rotated_glyph_renderer (
   input  logic                                 clock,
   input  logic                                 reset,
   // request transaction
   input  logic                                 start,
   output logic                                 busy,
   input  logic [srgr_pkg::X_W-1:0]             req_pos_x,
   input  logic [srgr_pkg::Y_W-1:0]             req_pos_y,
   input  logic [srgr_pkg::CODE_W-1:0]          req_char_code,
   input  logic [srgr_pkg::SCALE_W-1:0]         req_scale,
   input  logic [srgr_pkg::COLOR_W-1:0]         req_fg_color,
   input  logic [srgr_pkg::COLOR_W-1:0]         req_bg_color,
   // result transactions, one per cell column
   output logic                                 rsp_strobe,
   output logic [srgr_pkg::ADDR_W-1:0]          rsp_column_address,
   output srgr_pkg::mask_type                   rsp_write_mask,
   output srgr_pkg::mask_type                   rsp_fg_mask,
   output logic [srgr_pkg::COLOR_W-1:0]         rsp_out_fg_color,
   output logic [srgr_pkg::COLOR_W-1:0]         rsp_out_bg_color,
   output logic                                 rsp_last_column
);

   srgr_pkg::cmd_type    cmd;
   srgr_pkg::status_type status;

   // Sequencer: idle -> expand -> emit -> idle; expand returns straight to idle at scale 0.
   srgr_controller u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // Datapath: builds per-dot-column row masks once, then walks the columns,
   // stepping the rotated address down one physical row per logical column.
   srgr_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_char_code      (req_char_code),
      .req_scale          (req_scale),
      .req_fg_color       (req_fg_color),
      .req_bg_color       (req_bg_color),
      .rsp_strobe         (rsp_strobe),
      .rsp_column_address (rsp_column_address),
      .rsp_write_mask     (rsp_write_mask),
      .rsp_fg_mask        (rsp_fg_mask),
      .rsp_out_fg_color   (rsp_out_fg_color),
      .rsp_out_bg_color   (rsp_out_bg_color),
      .rsp_last_column    (rsp_last_column)
   );

   // a foreground bit only ever marks a written pixel
   a_fg_within_write: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_fg_mask & ~rsp_write_mask) == '0))
      else $error("fg_mask bit set on an unwritten pixel");

   // columns of a cell come back to back until the last one
   a_columns_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_column) |=> rsp_strobe)
      else $error("gap inside a character cell");

   // an accepted transaction makes the block busy
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // a result only follows work in progress
   a_strobe_needs_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobed without a transaction in progress");

endmodule

/* tb/scaled_rotated_glyph_renderer_test.sv */
// ----------------------------------------------------------------------------
// scaled_rotated_glyph_renderer_test
// Self-checking bench for the scaled, rotated 5x7 character renderer. A short
// table of directed requests covers the corners: screen edges, scale zero and
// saturation, every special glyph and blank codes. Random requests follow in
// bursts with gaps. Every cell column strobed out is compared against the
// columns expected by the bench, most of them from its behavioural model.
// ----------------------------------------------------------------------------
module scaled_rotated_glyph_renderer_test;

   // How the expected columns of a request are obtained
   typedef enum logic [1:0] {
      CHECK_PREDICTED,   // from the behavioural model
      CHECK_OFF_SCREEN,  // every column right of the screen: zero address and masks
      CHECK_NO_RESULT    // scale zero: nothing comes back
   } check_kind_type;

   typedef struct packed {
      logic [srgr_pkg::X_W-1:0]     pos_x;
      logic [srgr_pkg::Y_W-1:0]     pos_y;
      logic [srgr_pkg::CODE_W-1:0]  char_code;
      logic [srgr_pkg::SCALE_W-1:0] scale;
      logic [srgr_pkg::COLOR_W-1:0] fg_color;
      logic [srgr_pkg::COLOR_W-1:0] bg_color;
      check_kind_type               kind;
   } glyph_request_type;

   typedef struct packed {
      logic [srgr_pkg::ADDR_W-1:0]  column_address;
      srgr_pkg::mask_type           write_mask;
      srgr_pkg::mask_type           fg_mask;
      logic [srgr_pkg::COLOR_W-1:0] fg_color;
      logic [srgr_pkg::COLOR_W-1:0] bg_color;
      logic                         last_column;
   } cell_column_type;

   localparam int RANDOM_REQUESTS = 370;
   localparam int DRAIN_AT        = 180;  // mid-run pause until the queue empties
   localparam int TAIL_CYCLES     = 20;
   localparam int WATCHDOG_LIMIT  = 500;  // longest gap plus a full cell, several times

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [srgr_pkg::X_W-1:0]     req_pos_x;
   logic [srgr_pkg::Y_W-1:0]     req_pos_y;
   logic [srgr_pkg::CODE_W-1:0]  req_char_code;
   logic [srgr_pkg::SCALE_W-1:0] req_scale;
   logic [srgr_pkg::COLOR_W-1:0] req_fg_color;
   logic [srgr_pkg::COLOR_W-1:0] req_bg_color;
   check_kind_type               req_kind;   // bench-side tag travelling with the request

   logic                         rsp_strobe;
   logic [srgr_pkg::ADDR_W-1:0]  rsp_column_address;
   srgr_pkg::mask_type           rsp_write_mask;
   srgr_pkg::mask_type           rsp_fg_mask;
   logic [srgr_pkg::COLOR_W-1:0] rsp_out_fg_color;
   logic [srgr_pkg::COLOR_W-1:0] rsp_out_bg_color;
   logic                         rsp_last_column;

   cell_column_type pending_columns [$];
   int              failures;
   int              idle_cycles;
   int              burst_left;
   string           font_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ:.-";

   // Directed requests. Corners of the screen, scale zero and saturation,
   // each special glyph, and codes sitting just outside the font ranges.
   glyph_request_type directed_rows [$] = '{
      // top-left corner straight after reset
      '{10'd0,    9'd0,   "0",   4'd1,  16'hFFFF, 16'h0000, CHECK_PREDICTED},
      // whole cell right of the screen, widest scale field
      '{10'd1023, 9'd511, 8'hFF, 4'd15, 16'h0000, 16'hFFFF, CHECK_OFF_SCREEN},
      '{10'd100,  9'd100, "A",   4'd0,  16'h1234, 16'h5678, CHECK_NO_RESULT},
      // largest cell flush with the bottom-right corner: margins drawn
      '{10'd752,  9'd416, "W",   4'd8,  16'hF800, 16'h001F, CHECK_PREDICTED},
      // one pixel further: margins dropped, last column and rows clipped
      '{10'd753,  9'd417, "M",   4'd8,  16'h07E0, 16'hF81F, CHECK_PREDICTED},
      // scale above the maximum saturates
      '{10'd40,   9'd40,  "8",   4'd9,  16'h0F0F, 16'hF0F0, CHECK_PREDICTED},
      '{10'd0,    9'd0,   8'h61, 4'd15, 16'h8001, 16'h7FFE, CHECK_PREDICTED},
      '{10'd10,   9'd20,  "Z",   4'd2,  16'hFFFF, 16'h0000, CHECK_PREDICTED},
      '{10'd60,   9'd20,  ":",   4'd3,  16'h4321, 16'h8765, CHECK_PREDICTED},
      '{10'd90,   9'd20,  ".",   4'd1,  16'h00FF, 16'hFF00, CHECK_PREDICTED},
      '{10'd120,  9'd20,  "-",   4'd4,  16'hCAFE, 16'h0BAD, CHECK_PREDICTED},
      '{10'd160,  9'd20,  "9",   4'd2,  16'h1111, 16'h2222, CHECK_PREDICTED},
      // blank codes either side of the font ranges
      '{10'd200,  9'd30,  " ",   4'd1,  16'hFFFF, 16'h0001, CHECK_PREDICTED},
      '{10'd210,  9'd30,  "/",   4'd1,  16'hFFFF, 16'h0002, CHECK_PREDICTED},
      '{10'd220,  9'd30,  ";",   4'd1,  16'hFFFF, 16'h0004, CHECK_PREDICTED},
      '{10'd230,  9'd30,  "@",   4'd1,  16'hFFFF, 16'h0008, CHECK_PREDICTED},
      '{10'd240,  9'd30,  "[",   4'd1,  16'hFFFF, 16'h0010, CHECK_PREDICTED},
      '{10'd250,  9'd30,  ",",   4'd2,  16'hFFFF, 16'h0020, CHECK_PREDICTED},
      '{10'd260,  9'd30,  8'h80, 4'd1,  16'hFFFF, 16'h0040, CHECK_PREDICTED},
      // bottom edge: most rows clipped, then every row clipped
      '{10'd300,  9'd479, "E",   4'd2,  16'hA5A5, 16'h5A5A, CHECK_PREDICTED},
      '{10'd330,  9'd511, "H",   4'd8,  16'h3C3C, 16'hC3C3, CHECK_PREDICTED},
      // right edge: last on-screen column, then one column past it
      '{10'd799,  9'd100, "1",   4'd1,  16'h0001, 16'h8000, CHECK_PREDICTED},
      '{10'd795,  9'd100, "K",   4'd1,  16'h0002, 16'h4000, CHECK_PREDICTED},
      '{10'd400,  9'd240, "Q",   4'd5,  16'hAAAA, 16'h5555, CHECK_PREDICTED}
   };

   scaled_rotated_glyph_renderer dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_char_code      (req_char_code),
      .req_scale          (req_scale),
      .req_fg_color       (req_fg_color),
      .req_bg_color       (req_bg_color),
      .rsp_strobe         (rsp_strobe),
      .rsp_column_address (rsp_column_address),
      .rsp_write_mask     (rsp_write_mask),
      .rsp_fg_mask        (rsp_fg_mask),
      .rsp_out_fg_color   (rsp_out_fg_color),
      .rsp_out_bg_color   (rsp_out_bg_color),
      .rsp_last_column    (rsp_last_column)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Behavioural model of the renderer
   // ---------------------------------------------------------------------------

   // font entry of an ASCII code, -1 where the glyph is blank
   function automatic int font_entry(input logic [srgr_pkg::CODE_W-1:0] code);
      if (code >= "0" && code <= "9") return int'(code) - int'("0");
      if (code >= "A" && code <= "Z") return int'(code) - int'("A") + 10;
      if (code == ":") return 36;
      if (code == ".") return 37;
      if (code == "-") return 38;
      return -1;
   endfunction

   // one dot of the 5x7 font; rows packed top first, MSB of each row leftmost
   function automatic logic dot_set(input int entry, input int row, input int col);
      logic [34:0] dots;
      case (entry)
         0:  dots = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
         1:  dots = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
         2:  dots = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
         3:  dots = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
         4:  dots = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
         5:  dots = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
         6:  dots = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
         7:  dots = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
         8:  dots = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
         9:  dots = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
         10: dots = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
         11: dots = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
         12: dots = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
         13: dots = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
         14: dots = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
         15: dots = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
         16: dots = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
         17: dots = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
         18: dots = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
         19: dots = {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C};
         20: dots = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
         21: dots = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
         22: dots = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
         23: dots = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
         24: dots = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
         25: dots = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
         26: dots = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
         27: dots = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
         28: dots = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
         29: dots = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
         30: dots = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
         31: dots = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
         32: dots = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
         33: dots = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
         34: dots = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
         35: dots = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
         36: dots = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
         37: dots = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06};
         38: dots = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
         default: dots = '0;
      endcase
      return dots[34 - 5 * row - col];
   endfunction

   // Queues the cell columns one request should produce, left to right.
   function automatic void render_columns(input glyph_request_type r);
      int              dot_scale, ncols, nrows, cx, dc, dr, entry;
      logic            whole_cell;
      cell_column_type col;
      dot_scale = (r.scale > srgr_pkg::MAX_SCALE) ? srgr_pkg::MAX_SCALE : int'(r.scale);
      if (dot_scale == 0) return;
      ncols      = srgr_pkg::CELL_COLS * dot_scale;
      nrows      = srgr_pkg::CELL_ROWS * dot_scale;
      // margins are only drawn when the whole cell fits on screen
      whole_cell = (int'(r.pos_x) + ncols <= srgr_pkg::LOGICAL_WIDTH) &&
                   (int'(r.pos_y) + nrows <= srgr_pkg::LOGICAL_HEIGHT);
      entry      = font_entry(r.char_code);
      for (int c = 0; c < ncols; c++) begin
         col = '0;
         cx  = int'(r.pos_x) + c;
         dc  = c / dot_scale;
         if (cx < srgr_pkg::LOGICAL_WIDTH) begin
            // rotation: logical column x becomes physical row 799-x
            col.column_address = srgr_pkg::ADDR_W'(
               (srgr_pkg::LOGICAL_WIDTH - 1 - cx) * srgr_pkg::PHYS_WIDTH + int'(r.pos_y));
            for (int i = 0; i < nrows; i++) begin
               if (int'(r.pos_y) + i >= srgr_pkg::LOGICAL_HEIGHT) break;
               dr = i / dot_scale;
               if (dc < srgr_pkg::GLYPH_COLS && dr < srgr_pkg::GLYPH_ROWS) begin
                  // glyph area: clipped pixel by pixel
                  col.write_mask[i] = 1'b1;
                  col.fg_mask[i]    = dot_set(entry, dr, dc);
               end else if (whole_cell) begin
                  col.write_mask[i] = 1'b1;
               end
            end
         end
         col.fg_color    = r.fg_color;
         col.bg_color    = r.bg_color;
         col.last_column = (c == ncols - 1);
         pending_columns.push_back(col);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Monitor: request acceptance, result checking, watchdog
   // ---------------------------------------------------------------------------
   // Inputs move on the falling edge, so everything sampled here is settled.
   always @(posedge clock) begin : monitor
      glyph_request_type accepted;
      cell_column_type   want;
      int                ncols;
      if (!reset && start && !busy) begin
         accepted = '{req_pos_x, req_pos_y, req_char_code, req_scale,
                      req_fg_color, req_bg_color, req_kind};
         case (req_kind)
            CHECK_PREDICTED: render_columns(accepted);
            CHECK_OFF_SCREEN: begin
               // every column off screen: address and masks all zero
               ncols = srgr_pkg::CELL_COLS *
                       ((req_scale > srgr_pkg::MAX_SCALE) ? srgr_pkg::MAX_SCALE
                                                          : int'(req_scale));
               for (int c = 0; c < ncols; c++) begin
                  pending_columns.push_back('{'0, '0, '0, req_fg_color, req_bg_color,
                                              c == ncols - 1});
               end
            end
            CHECK_NO_RESULT: ;
            default: ;
         endcase
      end
      if (!reset && rsp_strobe) begin
         if (pending_columns.size() == 0) begin
            $error("column transaction with none expected: address %0h",
                   rsp_column_address);
            failures++;
         end else begin
            want = pending_columns.pop_front();
            if (rsp_column_address !== want.column_address) begin
               $error("column_address: expected %0h, got %0h",
                      want.column_address, rsp_column_address);
               failures++;
            end
            if (rsp_write_mask !== want.write_mask) begin
               $error("write_mask: expected %h, got %h", want.write_mask, rsp_write_mask);
               failures++;
            end
            if (rsp_fg_mask !== want.fg_mask) begin
               $error("fg_mask: expected %h, got %h", want.fg_mask, rsp_fg_mask);
               failures++;
            end
            if (rsp_out_fg_color !== want.fg_color) begin
               $error("out_fg_color: expected %h, got %h", want.fg_color, rsp_out_fg_color);
               failures++;
            end
            if (rsp_out_bg_color !== want.bg_color) begin
               $error("out_bg_color: expected %h, got %h", want.bg_color, rsp_out_bg_color);
               failures++;
            end
            if (rsp_last_column !== want.last_column) begin
               $error("last_column: expected %b, got %b", want.last_column, rsp_last_column);
               failures++;
            end
         end
      end
      // watchdog: any transaction in either direction counts as progress
      if ((start && !busy) || rsp_strobe) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------

   // Presents one request and returns at the falling edge after it is taken.
   // Requests go out in bursts; between bursts start drops for a random gap,
   // sometimes long enough to leave the block idle, sometimes none at all.
   task automatic send_request(input glyph_request_type r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 :
               ($urandom_range(0, 4) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 15);
         if (gap != 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_pos_x     = r.pos_x;
      req_pos_y     = r.pos_y;
      req_char_code = r.char_code;
      req_scale     = r.scale;
      req_fg_color  = r.fg_color;
      req_bg_color  = r.bg_color;
      req_kind      = r.kind;
      start         = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Holds off new requests until every expected column has come back.
   task automatic wait_for_drain();
      start = 1'b0;
      while (pending_columns.size() != 0) @(negedge clock);
   endtask

   // Random request: mostly small scales and cells that fit on screen, with
   // font characters; the rest reaches scale zero, saturation, blank codes
   // and cells hanging off the edges.
   function automatic glyph_request_type random_request();
      glyph_request_type r;
      int                pick, span;
      pick = $urandom_range(0, 99);
      if (pick < 3)       r.scale = 4'd0;
      else if (pick < 8)  r.scale = srgr_pkg::SCALE_W'($urandom_range(9, 15));
      else if (pick < 20) r.scale = srgr_pkg::SCALE_W'($urandom_range(4, 8));
      else                r.scale = srgr_pkg::SCALE_W'($urandom_range(1, 3));
      span = (r.scale > srgr_pkg::MAX_SCALE) ? srgr_pkg::MAX_SCALE : int'(r.scale);
      if (span == 0) span = 1;
      if ($urandom_range(0, 9) < 6) begin
         r.pos_x = srgr_pkg::X_W'($urandom_range(0,
                      srgr_pkg::LOGICAL_WIDTH - srgr_pkg::CELL_COLS * span));
         r.pos_y = srgr_pkg::Y_W'($urandom_range(0,
                      srgr_pkg::LOGICAL_HEIGHT - srgr_pkg::CELL_ROWS * span));
      end else begin
         r.pos_x = srgr_pkg::X_W'($urandom_range(0, 1023));
         r.pos_y = srgr_pkg::Y_W'($urandom_range(0, 511));
      end
      if ($urandom_range(0, 9) < 7) r.char_code = font_chars[$urandom_range(0, 38)];
      else                          r.char_code = srgr_pkg::CODE_W'($urandom_range(0, 255));
      r.fg_color = srgr_pkg::COLOR_W'($urandom);
      r.bg_color = srgr_pkg::COLOR_W'($urandom);
      r.kind     = CHECK_PREDICTED;
      return r;
   endfunction

   initial begin
      failures      = 0;
      idle_cycles   = 0;
      burst_left    = 0;
      reset         = 1'b1;
      start         = 1'b0;
      req_pos_x     = '0;
      req_pos_y     = '0;
      req_char_code = '0;
      req_scale     = '0;
      req_fg_color  = '0;
      req_bg_color  = '0;
      req_kind      = CHECK_PREDICTED;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[n]) send_request(directed_rows[n]);
      // let the directed part finish before random traffic starts
      wait_for_drain();

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == DRAIN_AT) wait_for_drain();
         send_request(random_request());
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (pending_columns.size() != 0) begin
         $error("%0d column transactions never arrived", pending_columns.size());
         failures++;
      end
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/srgr_pkg.sv
rtl/srgr_controller.sv
rtl/srgr_datapath.sv
rtl/scaled_rotated_glyph_renderer.sv
tb/scaled_rotated_glyph_renderer_test.sv
